### sv/csf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and helper functions of the camera select tally framer.
// No dependencies; imported by camera_select_tally_framer, tally_framer_checker and the testbench top.
package csf_pkg;

  // Field widths
  localparam int BUTTONS_W  = 4;
  localparam int CAMERA_W   = 2;
  localparam int MUX_W      = 3;
  localparam int TALLY_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int WIDX_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Message length in words
  localparam logic [WIDX_W-1:0] MESSAGE_WORDS = 3'd5;

  // Item kinds on the input tuser bit
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULTICAST_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TALLY_COMMAND     = 1'd1;

  // Register reset values
  localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'hFF;
  localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'h01;

  // Word positions within a message
  localparam logic [WIDX_W-1:0] WORD_ADDRESS = 3'd0;
  localparam logic [WIDX_W-1:0] WORD_LENGTH  = 3'd1;
  localparam logic [WIDX_W-1:0] WORD_COMMAND = 3'd2;
  localparam logic [WIDX_W-1:0] WORD_TALLY   = 3'd3;

  // Payload length byte sent second
  localparam logic [BYTE_W-1:0] LENGTH_BYTE = 8'd4;

  // Video mux code of each camera
  function automatic logic [MUX_W-1:0] mux_for(input logic [CAMERA_W-1:0] cam);
    logic [MUX_W-1:0] code;
    unique case (cam)
      2'd0:    code = 3'd5;
      2'd1:    code = 3'd4;
      2'd2:    code = 3'd2;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  // One-hot lamp of a camera
  function automatic logic [TALLY_W-1:0] lamp_for(input logic [CAMERA_W-1:0] cam);
    return TALLY_W'(1) << cam;
  endfunction

endpackage

### sv/camera_select_tally_framer.sv
`timescale 1ns / 1ps
// Camera selector with a five-word multidrop tally message framer.
// Depends on csf_pkg for widths, codes and the mux/lamp lookups.

// One item is taken per clock: an input beat is accepted whenever the result
// register is empty or its beat is being taken in the same cycle, and its
// single result beat appears in the next cycle. A button sample (tuser 0) that
// differs from the previous one selects the lowest newly pressed camera and,
// if no message is in flight, queues a tally message; a transmitter-ready
// tick (tuser 1) emits the next word of the message in flight. Every result
// beat carries the current mux code and lamp. After reset the start-up
// message for camera 0 is pending. Configuration writes take effect at once
// and should only be made while no beat is outstanding.
module camera_select_tally_framer (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [csf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csf_pkg::BYTE_W-1:0]          cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csf_pkg::IN_DATA_W-1:0]       in_tdata,   // [3:0] buttons, [7:4] zero
  input  logic                                in_tuser,   // [0] kind
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csf_pkg::OUT_DATA_W-1:0]      out_tdata,  // [2:0] mux_code, [6:3] tally_leds,
                                                          // [7] word_valid, [15:8] word_data
  output logic                                out_tuser,  // [0] address_flag
  output logic                                out_tlast   // word_last
);
  import csf_pkg::*;

  // Configuration registers
  logic [BYTE_W-1:0] address_r;
  logic [BYTE_W-1:0] command_r;

  // Selector and framer state
  logic [BUTTONS_W-1:0] last_buttons_r, last_buttons_nxt;
  logic [CAMERA_W-1:0]  camera_r, camera_nxt;
  logic                 sending_r, sending_nxt;
  logic [WIDX_W-1:0]    word_index_r, word_index_nxt;
  logic [TALLY_W-1:0]   msg_tally_r, msg_tally_nxt;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_addr_r, out_addr_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                 in_beat;
  logic [BUTTONS_W-1:0] buttons;
  logic [BUTTONS_W-1:0] pressed;
  logic                 word_valid;
  logic [BYTE_W-1:0]    word_data;
  logic                 pick;
  logic [CAMERA_W-1:0]  pick_cam;

  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign buttons   = in_tdata[BUTTONS_W-1:0];
  assign pressed   = buttons & ~last_buttons_r;

  // Lowest newly pressed button wins
  always_comb begin
    pick     = 1'b1;
    pick_cam = 2'd0;
    priority if (pressed[0]) pick_cam = 2'd0;
    else if (pressed[1])     pick_cam = 2'd1;
    else if (pressed[2])     pick_cam = 2'd2;
    else if (pressed[3])     pick_cam = 2'd3;
    else                     pick = 1'b0;
  end

  // Next state and result of the beat at the input
  always_comb begin
    last_buttons_nxt = last_buttons_r;
    camera_nxt       = camera_r;
    sending_nxt      = sending_r;
    word_index_nxt   = word_index_r;
    msg_tally_nxt    = msg_tally_r;
    word_valid       = 1'b0;
    word_data        = '0;
    out_addr_nxt     = 1'b0;
    out_last_nxt     = 1'b0;
    if (in_tuser == KIND_SAMPLE) begin
      if (buttons != last_buttons_r) begin
        last_buttons_nxt = buttons;
        if (pick) begin
          camera_nxt = pick_cam;
          if (!sending_r) begin
            msg_tally_nxt  = lamp_for(pick_cam);
            word_index_nxt = '0;
            sending_nxt    = 1'b1;
          end
        end
      end
    end else if (sending_r) begin
      word_valid = 1'b1;
      unique case (word_index_r)
        WORD_ADDRESS: begin
          word_data    = address_r;
          out_addr_nxt = 1'b1;
        end
        WORD_LENGTH:  word_data = LENGTH_BYTE;
        WORD_COMMAND: word_data = command_r;
        WORD_TALLY:   word_data = BYTE_W'(msg_tally_r);
        default:      word_data = '0;
      endcase
      // finish on the final word, or on any index past it
      if ({1'b0, word_index_r} + 4'd1 >= {1'b0, MESSAGE_WORDS}) begin
        out_last_nxt   = 1'b1;
        sending_nxt    = 1'b0;
        word_index_nxt = '0;
      end else begin
        word_index_nxt = word_index_r + 3'd1;
      end
    end
    // mux code and lamp follow the camera after this beat
    out_data_nxt = {word_data, word_valid, lamp_for(camera_nxt), mux_for(camera_nxt)};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r <= ADDRESS_RESET;
      command_r <= COMMAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MULTICAST_ADDRESS: address_r <= cfg_wdata;
        CFG_TALLY_COMMAND:     command_r <= cfg_wdata;
        default:               ;
      endcase
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_buttons_r <= '0;
      camera_r       <= '0;
      sending_r      <= 1'b1;
      word_index_r   <= '0;
      msg_tally_r    <= TALLY_W'(1);
    end else if (in_beat) begin
      last_buttons_r <= last_buttons_nxt;
      camera_r       <= camera_nxt;
      sending_r      <= sending_nxt;
      word_index_r   <= word_index_nxt;
      msg_tally_r    <= msg_tally_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= out_data_nxt;
      out_addr_r <= out_addr_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_addr_r;
  assign out_tlast  = out_last_r;

  // Word flags only on emitted words; address and last never together
  a_flags_need_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_addr_r || out_last_r) |-> out_data_r[7] && !(out_addr_r && out_last_r))
    else $error("word flag set without a valid word");

  // Lamp is always one-hot on a result beat
  a_lamp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_data_r[6:3]))
    else $error("tally lamp not one-hot");

  // Word index never leaves the message
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    word_index_r < MESSAGE_WORDS)
    else $error("word index out of range");

  // The index only moves while a message is in flight
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> word_index_r == '0)
    else $error("word index nonzero while idle");

endmodule

### tb/sv/tally_framer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the camera select tally framer: watches the register port and both streams,
// predicts each result beat and compares it field by field. Depends on csf_pkg only.
module tally_framer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csf_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [csf_pkg::IN_DATA_W-1:0]  in_tdata,   // [3:0] buttons, [7:4] zero
  input  logic                           in_tuser,   // [0] kind
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [csf_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] mux_code, [6:3] tally_leds,
                                                     // [7] word_valid, [15:8] word_data
  input  logic                           out_tuser,  // [0] address_flag
  input  logic                           out_tlast,  // word_last
  output int                             fail_count,
  output int                             beats_awaited,
  output int                             beats_checked,
  output int                             words_seen,
  output int                             messages_closed
);
  import csf_pkg::*;

  typedef struct packed {
    logic [MUX_W-1:0]   mux;
    logic [TALLY_W-1:0] lamp;
    logic               word_valid;
    logic [BYTE_W-1:0]  data;
    logic               addr_flag;
    logic               last;
  } status_beat_t;

  // Predicted selector and framer state
  logic [BUTTONS_W-1:0] prev_buttons;
  logic [CAMERA_W-1:0]  sel_camera;
  logic                 msg_busy;
  logic [WIDX_W-1:0]    next_word;
  logic [TALLY_W-1:0]   queued_lamp;
  logic [BYTE_W-1:0]    address_reg;
  logic [BYTE_W-1:0]    command_reg;

  status_beat_t awaited_beats[$];

  function automatic logic [MUX_W-1:0] switch_code(input logic [CAMERA_W-1:0] cam);
    case (cam)
      2'd0:    return 3'd5;
      2'd1:    return 3'd4;
      2'd2:    return 3'd2;
      default: return 3'd0;
    endcase
  endfunction

  // Advance the predicted state by one input beat and return the beat it should produce
  function automatic status_beat_t predict_beat(input logic kind,
                                                input logic [BUTTONS_W-1:0] btn);
    status_beat_t         beat;
    logic [BUTTONS_W-1:0] fresh;
    bit                   found;
    beat  = '0;
    found = 1'b0;
    if (kind == KIND_SAMPLE) begin
      if (btn != prev_buttons) begin
        fresh        = btn & ~prev_buttons;
        prev_buttons = btn;
        // lowest newly pressed button wins; a new message only when the line is free
        for (int i = 0; i < BUTTONS_W; i++) begin
          if (fresh[i] && !found) begin
            found      = 1'b1;
            sel_camera = CAMERA_W'(i);
            if (!msg_busy) begin
              queued_lamp = TALLY_W'(1) << i;
              next_word   = '0;
              msg_busy    = 1'b1;
            end
          end
        end
      end
    end else if (msg_busy) begin
      beat.word_valid = 1'b1;
      case (next_word)
        WORD_ADDRESS: begin
          beat.data      = address_reg;
          beat.addr_flag = 1'b1;
        end
        WORD_LENGTH:  beat.data = LENGTH_BYTE;
        WORD_COMMAND: beat.data = command_reg;
        WORD_TALLY:   beat.data = BYTE_W'(queued_lamp);
        default:      beat.data = '0;
      endcase
      if (int'(next_word) + 1 >= int'(MESSAGE_WORDS)) begin
        beat.last = 1'b1;
        msg_busy  = 1'b0;
        next_word = '0;
      end else begin
        next_word = next_word + 1'b1;
      end
    end
    beat.mux  = switch_code(sel_camera);
    beat.lamp = TALLY_W'(1) << sel_camera;
    return beat;
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare result beats first, then take register writes and new input beats
  always @(posedge clk) begin
    status_beat_t want;
    if (!rst_n) begin
      prev_buttons = '0;
      sel_camera   = '0;
      msg_busy     = 1'b1;
      next_word    = '0;
      queued_lamp  = 4'b0001;
      address_reg  = ADDRESS_RESET;
      command_reg  = COMMAND_RESET;
      awaited_beats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (out_tdata[7]) words_seen++;
        if (out_tlast) messages_closed++;
        if (awaited_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got tdata 0x%0h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = awaited_beats.pop_front();
          check_field("mux_code", BYTE_W'(want.mux), BYTE_W'(out_tdata[2:0]));
          check_field("tally_leds", BYTE_W'(want.lamp), BYTE_W'(out_tdata[6:3]));
          check_field("word_valid", BYTE_W'(want.word_valid), BYTE_W'(out_tdata[7]));
          check_field("word_data", want.data, out_tdata[15:8]);
          check_field("address_flag", BYTE_W'(want.addr_flag), BYTE_W'(out_tuser));
          check_field("word_last", BYTE_W'(want.last), BYTE_W'(out_tlast));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MULTICAST_ADDRESS: address_reg = cfg_wdata;
          CFG_TALLY_COMMAND:     command_reg = cfg_wdata;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_beats.push_back(predict_beat(in_tuser, in_tdata[BUTTONS_W-1:0]));
    end
    beats_awaited <= awaited_beats.size();
  end

endmodule

### tb/sv/tb_camera_select_tally_framer.sv
`timescale 1ns / 1ps
// Top of the camera select tally framer testbench: clock, reset, stimulus and verdict.
// Depends on csf_pkg, camera_select_tally_framer and tally_framer_checker.
module tb_camera_select_tally_framer;
  import csf_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int SEGMENTS     = 6;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 800000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [BYTE_W-1:0]     cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  int fail_count, beats_awaited, beats_checked, words_seen, messages_closed;
  int cycles;
  int items_sent, samples_sent, ticks_sent;
  bit no_gaps;
  bit hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  camera_select_tally_framer dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  tally_framer_checker u_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .beats_awaited, .beats_checked, .words_seen, .messages_closed
  );

  // Mostly short gaps, a few long ones; none at all in steady stretches
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic kind, input logic [BUTTONS_W-1:0] btn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'(btn);
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == KIND_TICK) ticks_sent++;
    else samples_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_beat(KIND_TICK, 4'($urandom));
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (beats_awaited != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly press-then-send episodes, with stray samples mixed in; the rest is noise, with an occasional drain
  task automatic run_segment(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        wait_results();
      end else if (r < 75) begin
        send_beat(KIND_SAMPLE, 4'($urandom));
        repeat ($urandom_range(3, 7)) begin
          if ($urandom_range(0, 99) < 15) send_beat(KIND_SAMPLE, 4'($urandom));
          send_beat(KIND_TICK, 4'($urandom));
        end
      end else begin
        send_beat(1'($urandom), 4'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start-up message for camera 0 at reset register values, then a tick while idle
    send_ticks(6);
    // Unchanged sample, a press, then a second press while the message is in flight
    send_beat(KIND_SAMPLE, 4'b0000);
    send_beat(KIND_SAMPLE, 4'b0010);
    send_beat(KIND_SAMPLE, 4'b0110);
    send_ticks(5);
    // Release with no new press, then camera 3 alone
    send_beat(KIND_SAMPLE, 4'b0100);
    send_beat(KIND_SAMPLE, 4'b1100);
    send_ticks(5);
    // Several new presses at once; leave the message half sent across a register change
    send_beat(KIND_SAMPLE, 4'b1111);
    send_ticks(3);
    wait_results();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          write_reg(CFG_MULTICAST_ADDRESS, 8'h00);
          write_reg(CFG_TALLY_COMMAND, 8'h00);
        end
        1: begin
          write_reg(CFG_MULTICAST_ADDRESS, 8'hFF);
          write_reg(CFG_TALLY_COMMAND, 8'hFF);
        end
        2: begin
          write_reg(CFG_MULTICAST_ADDRESS, 8'hA5);
          write_reg(CFG_TALLY_COMMAND, 8'h5A);
        end
        default: begin
          write_reg(CFG_MULTICAST_ADDRESS, 8'($urandom));
          write_reg(CFG_TALLY_COMMAND, 8'($urandom));
        end
      endcase
      no_gaps = (seg == 3);
      // Back-pressure: receiver holds off while the sender keeps offering
      if (seg == 1) hold_req = 1'b1;
      run_segment(RANDOM_ITEMS / SEGMENTS);
      wait_results();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d button samples and %0d ready ticks across %0d register settings.",
             samples_sent, ticks_sent, SEGMENTS + 1);
    $display("Checked %0d result beats: %0d serial words, %0d complete messages.",
             beats_checked, words_seen, messages_closed);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
